// ----- rtl/core/buddy_page_allocator_macros.svh -----
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bpa_pkg.sv -----
// shared constants, types and helpers of the buddy page allocator
package bpa_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int TOP_RANK   = 16;
   localparam int POOL_RESET = 4096;
   localparam int CFG_W      = 13;
   localparam int PAGE_W     = 13;
   localparam int IDX_W      = 12;
   localparam int RANK_W     = 5;
   localparam int OFF_W      = 24;
   localparam int ANS_W      = 13;
   localparam int PAGE_SHIFT = 12;
   localparam int WIDE_W     = 17;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;

   localparam logic [PAGE_W-1:0] NIL_PAGE = PAGE_W'(MAX_PAGES);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_COUNT = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_NOSPACE = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_CLEAR, OP_IDLE, OP_A_SEEK, OP_A_POP, OP_A_SPLIT, OP_A_PUSH, OP_A_TAKE,
      OP_COUNT, OP_F_CHK, OP_F_BUD, OP_F_BCHK, OP_U_TEST, OP_U_NEXT, OP_F_MERGE,
      OP_F_PUSH, OP_Q_CHK, OP_Q_TEST, OP_Q_NEXT, OP_RESP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } ctl_cmd_type;

   typedef struct packed {
      logic rank_bad;
      logic page_bad;
      logic cr_over;
      logic head_nil;
      logic split_more;
      logic taken_hit;
      logic merge_stop;
      logic bud_busy;
      logic cur_nil;
      logic cur_hit;
      logic q_hit;
      logic cr_one;
      logic out_free;
      logic clr_last;
   } dp_status_type;

   // rank of the single block that covers a fresh pool
   function automatic logic [RANK_W-1:0] top_rank_of(input logic [CFG_W-1:0] pages);
      logic [CFG_W-1:0]  m;
      logic [RANK_W-1:0] c;
      m = pages - CFG_W'(1);
      c = '0;
      for (int i = 0; i < CFG_W; i++) begin
         if (m[i]) c = RANK_W'(i + 1);
      end
      if (c >= RANK_W'(TOP_RANK)) return RANK_W'(TOP_RANK);
      return c + RANK_W'(1);
   endfunction

endpackage

// ----- rtl/core/bpa_req_if.sv -----
// request channel of the buddy page allocator
interface bpa_req_if;
   import bpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [RANK_W-1:0]   req_rank;
   logic [OFF_W-1:0]    byte_offset;
   modport source(output valid, command, req_rank, byte_offset, input ready);
   modport sink(input valid, command, req_rank, byte_offset, output ready);
endinterface

// ----- rtl/core/bpa_rsp_if.sv -----
// response channel of the buddy page allocator
interface bpa_rsp_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [OFF_W-1:0]   alloc_offset;
   logic [ANS_W-1:0]   answer;
   modport source(output valid, status, alloc_offset, answer, input ready);
   modport sink(input valid, status, alloc_offset, answer, output ready);
endinterface

// ----- rtl/core/buddy_page_allocator.sv -----
// top level of the buddy page allocator: sequencer plus datapath
// from acceptance to result valid: count reads its list count; allocate searches the ranks upward,
//   then splits the block down to the asked rank; free merges with each free buddy, walking its list
// query answers a taken page's rank directly, else scans the free lists from the top rank downward
// throughput: one item at a time; the response step waits while the result slot is full
// reset and every pool write run a clearing pass over the page tables before items are taken
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator (
   input  logic                         clock,
   input  logic                         reset,
   bpa_req_if.sink                      req_chan,
   bpa_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [bpa_pkg::CFG_W-1:0]    csr_wdata
);
   import bpa_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_st;
   logic          cfg_start;

   // a zero pool size is ignored
   assign cfg_start = csr_we && (csr_wdata != '0);

   // sequencer
   bpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg_start   (cfg_start),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .cmd         (ctl_cmd),
      .st          (dp_st)
   );

   // lists, tables and result slot
   bpa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg_start        (cfg_start),
      .cfg_pages        (csr_wdata),
      .req_rank         (req_chan.req_rank),
      .req_byte_offset  (req_chan.byte_offset),
      .cmd              (ctl_cmd),
      .st               (dp_st),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_alloc_offset (rsp_chan.alloc_offset),
      .rsp_answer       (rsp_chan.answer)
   );

   // checks
   `BPA_ASSERT_NEXT(a_busy_after_item, req_chan.valid && req_chan.ready,
      !req_chan.ready, "item accepted while busy")
   `BPA_ASSERT_NEXT(a_clear_after_cfg, cfg_start, !req_chan.ready,
      "item accepted during clearing")
   `BPA_ASSERT_NOW(a_rsp_from_resp, $rose(rsp_chan.valid), $past(ctl_cmd.op == OP_RESP),
      "result without response step")

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// sequencer of the buddy page allocator
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cfg_start,
   input  logic                  req_valid,
   input  logic [bpa_pkg::CMD_W-1:0] req_command,
   output logic                  req_ready,
   output bpa_pkg::ctl_cmd_type  cmd,
   input  bpa_pkg::dp_status_type st
);
   import bpa_pkg::*;

   typedef enum logic [18:0] {
      S_CLEAR   = 19'(1) << 0,
      S_IDLE    = 19'(1) << 1,
      S_A_SEEK  = 19'(1) << 2,
      S_A_POP   = 19'(1) << 3,
      S_A_SPLIT = 19'(1) << 4,
      S_A_PUSH  = 19'(1) << 5,
      S_A_TAKE  = 19'(1) << 6,
      S_COUNT   = 19'(1) << 7,
      S_F_CHK   = 19'(1) << 8,
      S_F_BUD   = 19'(1) << 9,
      S_F_BCHK  = 19'(1) << 10,
      S_U_TEST  = 19'(1) << 11,
      S_U_NEXT  = 19'(1) << 12,
      S_F_MERGE = 19'(1) << 13,
      S_F_PUSH  = 19'(1) << 14,
      S_Q_CHK   = 19'(1) << 15,
      S_Q_TEST  = 19'(1) << 16,
      S_Q_NEXT  = 19'(1) << 17,
      S_RESP    = 19'(1) << 18
   } state_type;

   state_type state_ff, state_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.accept = (state_ff == S_IDLE) && req_valid;

   // datapath operation for each state
   always_comb begin
      case (state_ff)
         S_CLEAR:   cmd.op = OP_CLEAR;
         S_IDLE:    cmd.op = OP_IDLE;
         S_A_SEEK:  cmd.op = OP_A_SEEK;
         S_A_POP:   cmd.op = OP_A_POP;
         S_A_SPLIT: cmd.op = OP_A_SPLIT;
         S_A_PUSH:  cmd.op = OP_A_PUSH;
         S_A_TAKE:  cmd.op = OP_A_TAKE;
         S_COUNT:   cmd.op = OP_COUNT;
         S_F_CHK:   cmd.op = OP_F_CHK;
         S_F_BUD:   cmd.op = OP_F_BUD;
         S_F_BCHK:  cmd.op = OP_F_BCHK;
         S_U_TEST:  cmd.op = OP_U_TEST;
         S_U_NEXT:  cmd.op = OP_U_NEXT;
         S_F_MERGE: cmd.op = OP_F_MERGE;
         S_F_PUSH:  cmd.op = OP_F_PUSH;
         S_Q_CHK:   cmd.op = OP_Q_CHK;
         S_Q_TEST:  cmd.op = OP_Q_TEST;
         S_Q_NEXT:  cmd.op = OP_Q_NEXT;
         S_RESP:    cmd.op = OP_RESP;
         default:   cmd.op = OP_IDLE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:   if (st.clr_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_ALLOC: state_in = S_A_SEEK;
                  CMD_FREE:  state_in = S_F_CHK;
                  CMD_QUERY: state_in = S_Q_CHK;
                  default:   state_in = S_COUNT;
               endcase
            end
         end
         S_A_SEEK: begin
            if (st.rank_bad || st.cr_over) state_in = S_RESP;
            else if (!st.head_nil) state_in = S_A_POP;
         end
         S_A_POP:   state_in = S_A_SPLIT;
         S_A_SPLIT: state_in = st.split_more ? S_A_PUSH : S_A_TAKE;
         S_A_PUSH:  state_in = S_A_SPLIT;
         S_A_TAKE:  state_in = S_RESP;
         S_COUNT:   state_in = S_RESP;
         S_F_CHK:   state_in = (st.page_bad || !st.taken_hit) ? S_RESP : S_F_BUD;
         S_F_BUD:   state_in = st.merge_stop ? S_F_PUSH : S_F_BCHK;
         S_F_BCHK:  state_in = st.bud_busy ? S_F_PUSH : S_U_TEST;
         S_U_TEST:  state_in = st.cur_nil ? S_F_MERGE : S_U_NEXT;
         S_U_NEXT:  state_in = st.cur_hit ? S_F_MERGE : S_U_TEST;
         S_F_MERGE: state_in = S_F_BUD;
         S_F_PUSH:  state_in = S_RESP;
         S_Q_CHK:   state_in = (st.page_bad || st.taken_hit) ? S_RESP : S_Q_TEST;
         S_Q_TEST: begin
            if (st.cur_nil) begin
               if (st.cr_one) state_in = S_RESP;
            end else if (st.q_hit) begin
               state_in = S_RESP;
            end else begin
               state_in = S_Q_NEXT;
            end
         end
         S_Q_NEXT:  state_in = S_Q_TEST;
         S_RESP:    if (st.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // state register, a pool write restarts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else if (cfg_start) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/bpa_datapath.sv -----
// free lists, page tables and result registers of the buddy page allocator
module bpa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cfg_start,
   input  logic [bpa_pkg::CFG_W-1:0]      cfg_pages,
   input  logic [bpa_pkg::RANK_W-1:0]     req_rank,
   input  logic [bpa_pkg::OFF_W-1:0]      req_byte_offset,
   input  bpa_pkg::ctl_cmd_type           cmd,
   output bpa_pkg::dp_status_type         st,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bpa_pkg::STAT_W-1:0]     rsp_status,
   output logic [bpa_pkg::OFF_W-1:0]      rsp_alloc_offset,
   output logic [bpa_pkg::ANS_W-1:0]      rsp_answer
);
   import bpa_pkg::*;

   // page tables
   logic [PAGE_W-1:0] next_link_ff [0:MAX_PAGES-1];
   logic [RANK_W-1:0] page_rank_ff [0:MAX_PAGES-1];
   logic              page_taken_ff [0:MAX_PAGES-1];
   logic [PAGE_W-1:0] next_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;
   logic              taken_rd_ff;

   // per-rank list heads and counts
   logic [PAGE_W-1:0] head_ff [0:TOP_RANK];
   logic [PAGE_W-1:0] cnt_ff  [0:TOP_RANK];

   logic [CFG_W-1:0]  pool_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [RANK_W-1:0] rank_ff, cr_ff, prank_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [IDX_W-1:0]  blk_ff;
   logic [WIDE_W-1:0] bud_ff;
   logic [PAGE_W-1:0] cur_ff, prev_ff;
   logic              found_ff;
   logic [STAT_W-1:0] status_ff;
   logic [OFF_W-1:0]  aoff_ff;
   logic [ANS_W-1:0]  answer_ff;
   logic              out_valid_ff;
   logic [STAT_W-1:0] out_status_ff;
   logic [OFF_W-1:0]  out_aoff_ff;
   logic [ANS_W-1:0]  out_answer_ff;

   logic [CFG_W-1:0]  cfg_sat;
   logic [RANK_W-1:0] top_new, top_cur, top_reset, clamp_rank;
   logic [PAGE_W-1:0] head_cur, cnt_cur;
   logic [WIDE_W-1:0] blk_wide, pool_wide, cur_wide, size_w, bud_w, split_bud;
   logic              aligned;
   logic [IDX_W-1:0]  new_blk, page_idx;
   logic [IDX_W-1:0]  next_ra, rt_ra;
   logic              next_we, rank_we, tk_we;
   logic [IDX_W-1:0]  next_wa, rank_wa, tk_wa;
   logic [PAGE_W-1:0] next_wd;
   logic [RANK_W-1:0] rank_wd;
   logic              tk_wd;

   // pool size and fresh top rank
   assign cfg_sat   = (cfg_pages > CFG_W'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : cfg_pages;
   assign top_new   = top_rank_of(cfg_sat);
   assign top_cur   = top_rank_of(pool_ff);
   assign top_reset = top_rank_of(CFG_W'(POOL_RESET));

   // list head and count at the current rank
   assign st.cr_over = cr_ff > RANK_W'(TOP_RANK);
   assign head_cur   = st.cr_over ? NIL_PAGE : head_ff[cr_ff];
   assign cnt_cur    = st.cr_over ? '0 : cnt_ff[cr_ff];

   // buddy arithmetic
   assign blk_wide  = WIDE_W'(blk_ff);
   assign pool_wide = WIDE_W'(pool_ff);
   assign cur_wide  = WIDE_W'(cur_ff);
   assign size_w    = WIDE_W'(1) << (cr_ff - RANK_W'(1));
   assign aligned   = (blk_wide & ((size_w << 1) - WIDE_W'(1))) == '0;
   assign bud_w     = aligned ? blk_wide + size_w : blk_wide - size_w;
   assign split_bud = blk_wide + (size_w >> 1);
   assign new_blk   = (bud_ff < blk_wide) ? bud_ff[IDX_W-1:0] : blk_ff;
   assign page_idx  = off_ff[OFF_W-1:PAGE_SHIFT];
   assign clamp_rank = (rank_rd_ff == '0 || rank_rd_ff > RANK_W'(TOP_RANK)) ?
                       RANK_W'(1) : rank_rd_ff;

   // status toward the sequencer
   assign st.rank_bad   = (rank_ff == '0) || (rank_ff > RANK_W'(TOP_RANK));
   assign st.page_bad   = (off_ff[PAGE_SHIFT-1:0] != '0) ||
                          (CFG_W'(page_idx) >= pool_ff);
   assign st.head_nil   = head_cur[PAGE_W-1];
   assign st.split_more = cr_ff > rank_ff;
   assign st.taken_hit  = taken_rd_ff;
   assign st.merge_stop = (cr_ff >= RANK_W'(TOP_RANK)) || (bud_w >= pool_wide);
   assign st.bud_busy   = taken_rd_ff || (rank_rd_ff != cr_ff);
   assign st.cur_nil    = cur_ff[PAGE_W-1];
   assign st.cur_hit    = (cur_wide == bud_ff);
   assign st.q_hit      = (blk_wide >= cur_wide) && (blk_wide < cur_wide + size_w);
   assign st.cr_one     = (cr_ff == RANK_W'(1));
   assign st.out_free   = !out_valid_ff || rsp_ready;
   assign st.clr_last   = (clr_ff == '1);

   // read addresses
   assign next_ra = (cmd.op == OP_A_SEEK) ? head_cur[IDX_W-1:0] : cur_ff[IDX_W-1:0];
   assign rt_ra   = (cmd.op == OP_F_BUD) ? bud_w[IDX_W-1:0] :
                    req_byte_offset[OFF_W-1:PAGE_SHIFT];

   // table writes
   always_comb begin
      next_we = 1'b0; next_wa = blk_ff; next_wd = NIL_PAGE;
      rank_we = 1'b0; rank_wa = blk_ff; rank_wd = RANK_W'(1);
      tk_we   = 1'b0; tk_wa   = blk_ff; tk_wd   = 1'b0;
      case (cmd.op)
         OP_CLEAR: begin
            next_we = 1'b1; next_wa = clr_ff;
            rank_we = 1'b1; rank_wa = clr_ff;
            rank_wd = (clr_ff == '0) ? top_cur : RANK_W'(1);
            tk_we   = 1'b1; tk_wa = clr_ff;
         end
         OP_A_POP: next_we = 1'b1;
         OP_A_SPLIT: begin
            rank_we = st.split_more;
            rank_wd = cr_ff - RANK_W'(1);
         end
         OP_A_PUSH: begin
            if (bud_ff < pool_wide) begin
               next_we = 1'b1; next_wa = bud_ff[IDX_W-1:0]; next_wd = head_cur;
               rank_we = 1'b1; rank_wa = bud_ff[IDX_W-1:0]; rank_wd = cr_ff;
               tk_we   = 1'b1; tk_wa   = bud_ff[IDX_W-1:0];
            end
         end
         OP_A_TAKE: begin
            tk_we = 1'b1; tk_wd = 1'b1;
         end
         OP_F_CHK:  tk_we = !st.page_bad && taken_rd_ff;
         OP_U_NEXT: begin
            next_we = st.cur_hit && !prev_ff[PAGE_W-1];
            next_wa = prev_ff[IDX_W-1:0];
            next_wd = next_rd_ff;
         end
         OP_F_MERGE: begin
            next_we = found_ff; next_wa = bud_ff[IDX_W-1:0];
            rank_we = 1'b1; rank_wa = new_blk; rank_wd = cr_ff + RANK_W'(1);
         end
         OP_F_PUSH: begin
            next_we = 1'b1; next_wd = head_cur;
         end
         default: ;
      endcase
   end

   // page table memories
   always_ff @(posedge clock) begin
      if (next_we) next_link_ff[next_wa] <= next_wd;
      if (rank_we) page_rank_ff[rank_wa] <= rank_wd;
      if (tk_we) page_taken_ff[tk_wa] <= tk_wd;
      next_rd_ff  <= next_link_ff[next_ra];
      rank_rd_ff  <= page_rank_ff[rt_ra];
      taken_rd_ff <= page_taken_ff[rt_ra];
   end

   // working registers, lists and result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= CFG_W'(POOL_RESET);
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r <= TOP_RANK; r++) begin
            head_ff[r] <= (RANK_W'(r) == top_reset) ? '0 : NIL_PAGE;
            cnt_ff[r]  <= (RANK_W'(r) == top_reset) ? PAGE_W'(1) : '0;
         end
      end else begin
         if (out_valid_ff && rsp_ready && (cfg_start || cmd.op != OP_RESP))
            out_valid_ff <= 1'b0;
         if (cfg_start) begin
            pool_ff <= cfg_sat;
            clr_ff  <= '0;
            for (int r = 0; r <= TOP_RANK; r++) begin
               head_ff[r] <= (RANK_W'(r) == top_new) ? '0 : NIL_PAGE;
               cnt_ff[r]  <= (RANK_W'(r) == top_new) ? PAGE_W'(1) : '0;
            end
         end else begin
            case (cmd.op)
               OP_CLEAR: clr_ff <= clr_ff + IDX_W'(1);
               OP_IDLE: begin
                  if (cmd.accept) begin
                     off_ff    <= req_byte_offset;
                     rank_ff   <= req_rank;
                     cr_ff     <= req_rank;
                     blk_ff    <= req_byte_offset[OFF_W-1:PAGE_SHIFT];
                     status_ff <= STAT_OK;
                     aoff_ff   <= '0;
                     answer_ff <= '0;
                  end
               end
               OP_A_SEEK: begin
                  if (st.rank_bad) status_ff <= STAT_INVALID;
                  else if (st.cr_over) status_ff <= STAT_NOSPACE;
                  else if (st.head_nil) cr_ff <= cr_ff + RANK_W'(1);
                  else blk_ff <= head_cur[IDX_W-1:0];
               end
               OP_A_POP: begin
                  head_ff[cr_ff] <= next_rd_ff;
                  cnt_ff[cr_ff]  <= cnt_cur - PAGE_W'(1);
               end
               OP_A_SPLIT: begin
                  if (st.split_more) begin
                     cr_ff  <= cr_ff - RANK_W'(1);
                     bud_ff <= split_bud;
                  end
               end
               OP_A_PUSH: begin
                  if (bud_ff < pool_wide) begin
                     head_ff[cr_ff] <= bud_ff[PAGE_W-1:0];
                     cnt_ff[cr_ff]  <= cnt_cur + PAGE_W'(1);
                  end
               end
               OP_A_TAKE: aoff_ff <= {blk_ff, {PAGE_SHIFT{1'b0}}};
               OP_COUNT: begin
                  if (st.rank_bad) status_ff <= STAT_INVALID;
                  else answer_ff <= cnt_cur;
               end
               OP_F_CHK: begin
                  if (st.page_bad || !taken_rd_ff) status_ff <= STAT_INVALID;
                  else cr_ff <= clamp_rank;
               end
               OP_F_BUD: if (!st.merge_stop) bud_ff <= bud_w;
               OP_F_BCHK: begin
                  cur_ff   <= head_cur;
                  prev_ff  <= NIL_PAGE;
                  found_ff <= 1'b0;
               end
               OP_U_NEXT: begin
                  if (st.cur_hit) begin
                     found_ff <= 1'b1;
                     if (prev_ff[PAGE_W-1]) head_ff[cr_ff] <= next_rd_ff;
                  end else begin
                     prev_ff <= cur_ff;
                     cur_ff  <= next_rd_ff;
                  end
               end
               OP_F_MERGE: begin
                  if (found_ff) cnt_ff[cr_ff] <= cnt_cur - PAGE_W'(1);
                  blk_ff <= new_blk;
                  cr_ff  <= cr_ff + RANK_W'(1);
               end
               OP_F_PUSH: begin
                  head_ff[cr_ff] <= PAGE_W'(blk_ff);
                  cnt_ff[cr_ff]  <= cnt_cur + PAGE_W'(1);
               end
               OP_Q_CHK: begin
                  if (st.page_bad) begin
                     status_ff <= STAT_INVALID;
                  end else if (taken_rd_ff) begin
                     answer_ff <= ANS_W'(rank_rd_ff);
                  end else begin
                     prank_ff <= rank_rd_ff;
                     cr_ff    <= RANK_W'(TOP_RANK);
                     cur_ff   <= head_ff[TOP_RANK];
                  end
               end
               OP_Q_TEST: begin
                  if (st.cur_nil) begin
                     if (st.cr_one) begin
                        answer_ff <= ANS_W'(prank_ff);
                     end else begin
                        cr_ff  <= cr_ff - RANK_W'(1);
                        cur_ff <= head_ff[cr_ff - RANK_W'(1)];
                     end
                  end else if (st.q_hit) begin
                     answer_ff <= ANS_W'(cr_ff);
                  end
               end
               OP_Q_NEXT: cur_ff <= next_rd_ff;
               OP_RESP: begin
                  if (st.out_free) begin
                     out_valid_ff  <= 1'b1;
                     out_status_ff <= status_ff;
                     out_aoff_ff   <= aoff_ff;
                     out_answer_ff <= answer_ff;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_alloc_offset = out_aoff_ff;
   assign rsp_answer       = out_answer_ff;

endmodule
